[design/vgdq_pkg.sv]
// Shared constants, types and helpers for the voxel grid dedup quantizer.
package vgdq_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int INDEX_BITS  = 16;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int KEY_W       = 3 * INDEX_BITS;
  localparam int CW          = INDEX_BITS + 33;

  localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;

  localparam logic [31:0] CFG_RESET_VALUE    = 32'd65536;
  localparam logic [7:0]  CFG_INV_VOXEL_SIZE = 8'd0;
  localparam logic [7:0]  CFG_VOXEL_SIZE     = 8'd1;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_MUL,
    FR_QUANT,
    FR_MUL2,
    FR_HASH,
    FR_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BK_SWEEP,
    BK_IDLE,
    BK_READ,
    BK_CMP
  } back_state_t;

  typedef struct packed {
    op_t               op;
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] pos;
    logic [31:0]       cx;
    logic [31:0]       cy;
    logic [31:0]       cz;
  } item_t;

  typedef struct packed {
    logic init;
  } back_status_t;

  function automatic logic [31:0] sat_center(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] hi;
    logic signed [CW-1:0] lo;
    hi = CW'(signed'(32'sh7FFFFFFF));
    lo = CW'(signed'(32'sh80000000));
    if (v > hi) begin
      return 32'h7FFFFFFF;
    end else if (v < lo) begin
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

endpackage

[design/vgdq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module vgdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/vgdq_queue.sv]
// Two-entry queue carrying classified items from front to back.
module vgdq_queue
  import vgdq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t item_in,
  output logic  full,
  input  logic  pop,
  output item_t item_out,
  output logic  empty
);

  item_t      mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign item_out = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) begin
        wptr <= ~wptr;
      end
      if (pop && !empty) begin
        rptr <= ~rptr;
      end
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

[design/vgdq_front.sv]
// Front end: quantise coordinates, compute centres and hash slot.
module vgdq_front
  import vgdq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic        opcode,
  input  logic [31:0] coord_x,
  input  logic [31:0] coord_y,
  input  logic [31:0] coord_z,
  input  logic [31:0] inv_voxel_size,
  input  logic [31:0] voxel_size,
  output logic        idle,
  input  logic        q_full,
  output logic        q_push,
  output item_t       q_item
);

  front_state_t state;
  front_state_t state_next;

  op_t                          op;
  logic [31:0]                  crd   [3];
  logic                         neg   [3];
  logic [63:0]                  prod  [3];
  logic signed [INDEX_BITS-1:0] idx   [3];
  logic signed [CW-1:0]         cprod [3];
  logic [31:0]                  pp    [16];
  logic [KEY_W-1:0]             key;
  item_t                        item;

  logic [31:0]                  mag_n   [3];
  logic [63:0]                  prod_n  [3];
  logic signed [INDEX_BITS-1:0] idx_n   [3];
  logic signed [CW-1:0]         cprod_n [3];
  logic [31:0]                  pp_n    [16];
  logic [63:0]                  hash;
  logic [63:0]                  key64;
  item_t                        item_n;

  always_comb begin
    logic [32:0] q;
    logic [32:0] lim;
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    lim = 33'd1 << (INDEX_BITS - 1);
    b   = CW'($signed({1'b0, voxel_size}));
    for (int k = 0; k < 3; k++) begin
      mag_n[k]  = neg[k] ? (32'd0 - crd[k]) : crd[k];
      prod_n[k] = 64'(mag_n[k]) * 64'(inv_voxel_size);
      q = 33'(({1'b0, prod[k]} + 65'h80000000) >> 32);
      if (neg[k]) begin
        if (q > lim) q = lim;
        idx_n[k] = INDEX_BITS'(33'd0 - q);
      end else begin
        if (q > lim - 33'd1) q = lim - 33'd1;
        idx_n[k] = INDEX_BITS'(q);
      end
      a = CW'(idx[k]);
      cprod_n[k] = a * b;
    end
  end

  assign key64 = 64'(key);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        if (i + j < 4) begin
          pp_n[4*i+j] = 32'(key64[16*i +: 16]) * 32'(HASH_MULT[16*j +: 16]);
        end else begin
          pp_n[4*i+j] = 32'd0;
        end
      end
    end
    hash = 64'd0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        hash = hash + (64'(pp[4*i+j]) << (16 * (i + j)));
      end
    end
    item_n.op  = op;
    item_n.key = key;
    item_n.pos = ADDR_W'(hash[63:32] % TABLE_DEPTH);
    item_n.cx  = sat_center(cprod[0]);
    item_n.cy  = sat_center(cprod[1]);
    item_n.cz  = sat_center(cprod[2]);
  end

  always_comb begin
    state_next = state;
    q_push     = 1'b0;
    idle       = 1'b0;
    unique case (state)
      FR_IDLE: begin
        idle = 1'b1;
        if (take) state_next = FR_MUL;
      end
      FR_MUL:   state_next = FR_QUANT;
      FR_QUANT: state_next = FR_MUL2;
      FR_MUL2:  state_next = FR_HASH;
      FR_HASH:  state_next = FR_PUSH;
      FR_PUSH: begin
        if (!q_full) begin
          q_push     = 1'b1;
          state_next = FR_IDLE;
        end
      end
      default: state_next = FR_IDLE;
    endcase
  end

  assign q_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      FR_IDLE: begin
        if (take) begin
          op     <= op_t'(opcode);
          crd[0] <= coord_x;
          crd[1] <= coord_y;
          crd[2] <= coord_z;
          neg[0] <= coord_x[31];
          neg[1] <= coord_y[31];
          neg[2] <= coord_z[31];
        end
      end
      FR_MUL: begin
        for (int k = 0; k < 3; k++) prod[k] <= prod_n[k];
      end
      FR_QUANT: begin
        for (int k = 0; k < 3; k++) idx[k] <= idx_n[k];
        key <= {idx_n[2], idx_n[1], idx_n[0]};
      end
      FR_MUL2: begin
        for (int k = 0; k < 3; k++) cprod[k] <= cprod_n[k];
        for (int m = 0; m < 16; m++) pp[m] <= pp_n[m];
      end
      FR_HASH: item <= item_n;
      FR_PUSH: ;
      default: ;
    endcase
  end

endmodule

[design/vgdq_back.sv]
// Back end: probe and update the voxel set, sweep it on a clear, hold the result beat.
module vgdq_back
  import vgdq_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         q_empty,
  input  item_t        q_item,
  output logic         q_pop,
  output back_status_t status,
  output logic         out_valid,
  input  logic         out_take,
  output logic         out_is_new,
  output logic [31:0]  out_cx,
  output logic [31:0]  out_cy,
  output logic [31:0]  out_cz,
  output logic         out_full
);

  back_state_t state;
  back_state_t state_next;

  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] n;
  logic [ADDR_W-1:0] sweep;
  logic              clr;
  logic              init;
  item_t             cur;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [KEY_W:0]    ram_wdata;
  logic [KEY_W:0]    ram_rdata;

  vgdq_ram #(
    .WIDTH (KEY_W + 1),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  assign status.init = init;

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = pos;
    ram_wdata  = {1'b1, cur.key};
    unique case (state)
      BK_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep;
        ram_wdata = '0;
        if (sweep == ADDR_W'(TABLE_DEPTH - 1)) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        if (!q_empty && !out_valid) begin
          q_pop      = 1'b1;
          state_next = (q_item.op == OP_CLEAR) ? BK_SWEEP : BK_READ;
        end
      end
      BK_READ: state_next = BK_CMP;
      BK_CMP: begin
        if (!ram_rdata[KEY_W]) begin
          ram_we     = 1'b1;
          state_next = BK_IDLE;
        end else if (ram_rdata[KEY_W-1:0] == cur.key) begin
          state_next = BK_IDLE;
        end else if (n == ADDR_W'(TABLE_DEPTH - 1)) begin
          state_next = BK_IDLE;
        end else begin
          state_next = BK_READ;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_SWEEP;
      sweep     <= '0;
      clr       <= 1'b0;
      init      <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_take) out_valid <= 1'b0;
      unique case (state)
        BK_SWEEP: begin
          sweep <= sweep + 1'b1;
          if (sweep == ADDR_W'(TABLE_DEPTH - 1)) begin
            init <= 1'b0;
            if (clr) out_valid <= 1'b1;
          end
        end
        BK_IDLE: begin
          if (!q_empty && !out_valid) begin
            sweep <= '0;
            clr   <= (q_item.op == OP_CLEAR);
          end
        end
        BK_READ: ;
        BK_CMP: begin
          if (state_next == BK_IDLE) out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_SWEEP: begin
        out_is_new <= 1'b0;
        out_full   <= 1'b0;
        out_cx     <= '0;
        out_cy     <= '0;
        out_cz     <= '0;
      end
      BK_IDLE: begin
        if (!q_empty && !out_valid) begin
          cur <= q_item;
          pos <= q_item.pos;
          n   <= '0;
        end
      end
      BK_READ: ;
      BK_CMP: begin
        out_cx     <= cur.cx;
        out_cy     <= cur.cy;
        out_cz     <= cur.cz;
        out_is_new <= !ram_rdata[KEY_W];
        out_full   <= ram_rdata[KEY_W] && (ram_rdata[KEY_W-1:0] != cur.key)
                      && (n == ADDR_W'(TABLE_DEPTH - 1));
        pos <= (pos == ADDR_W'(TABLE_DEPTH - 1)) ? '0 : pos + 1'b1;
        n   <= n + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

[design/voxel_grid_dedup_quantizer_core.sv]
// The front end steps through multiply, quantise, second multiply, hash and push states.
// It takes a new point only from its idle state, so its state sequence limits the rate of points.
// The back end reads then compares each probed slot, as the table RAM's read port is registered.
// A clear beat sweeps every table slot in the back end before its result beat is shown.
// Reset is synchronous; after it a sweep of every slot empties the table, full held high.
// Top level of the voxel grid dedup quantizer.
module voxel_grid_dedup_quantizer_core
  import vgdq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        opcode,
  input  logic [31:0] coord_x,
  input  logic [31:0] coord_y,
  input  logic [31:0] coord_z,
  output logic        empty,
  input  logic        pop,
  output logic        is_new,
  output logic [31:0] voxel_center_x,
  output logic [31:0] voxel_center_y,
  output logic [31:0] voxel_center_z,
  output logic        table_full,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0]  inv_voxel_size;
  logic [31:0]  voxel_size;
  logic         front_idle;
  logic         q_full;
  logic         q_push;
  item_t        q_in;
  logic         q_pop;
  item_t        q_out;
  logic         q_empty;
  back_status_t bstat;
  logic         out_valid;

  assign cfg_ready = 1'b1;
  assign full      = !front_idle || bstat.init;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_voxel_size <= CFG_RESET_VALUE;
      voxel_size     <= CFG_RESET_VALUE;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_INV_VOXEL_SIZE) inv_voxel_size <= cfg_data;
      if (cfg_index == CFG_VOXEL_SIZE) voxel_size <= cfg_data;
    end
  end

  vgdq_front u_front (
    .clk            (clk),
    .rst            (rst),
    .take           (push && !full),
    .opcode         (opcode),
    .coord_x        (coord_x),
    .coord_y        (coord_y),
    .coord_z        (coord_z),
    .inv_voxel_size (inv_voxel_size),
    .voxel_size     (voxel_size),
    .idle           (front_idle),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_in)
  );

  vgdq_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .item_in  (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .item_out (q_out),
    .empty    (q_empty)
  );

  vgdq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_item     (q_out),
    .q_pop      (q_pop),
    .status     (bstat),
    .out_valid  (out_valid),
    .out_take   (pop),
    .out_is_new (is_new),
    .out_cx     (voxel_center_x),
    .out_cy     (voxel_center_y),
    .out_cz     (voxel_center_z),
    .out_full   (table_full)
  );

endmodule

[design/vgdq_checker.sv]
// Port-level checker for the voxel grid dedup quantizer, bound to the top level.
module vgdq_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic        is_new,
  input logic        table_full,
  input logic [31:0] voxel_center_x
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result beat present after reset");

  a_reset_full: assert property (@(posedge clk) rst |=> full)
    else $error("input open during table sweep");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(is_new && table_full))
    else $error("new and full flagged together");

  a_beat_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(voxel_center_x) && $stable(is_new)))
    else $error("stalled result beat changed");

endmodule

bind voxel_grid_dedup_quantizer_core vgdq_checker u_vgdq_checker (
  .clk            (clk),
  .rst            (rst),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .is_new         (is_new),
  .table_full     (table_full),
  .voxel_center_x (voxel_center_x)
);
